[src/id_find_or_allocate_map_defines.svh]
// Assertion macros used by the verification files of the identifier map.
// Depends on nothing; included by the checker file.
`ifndef ID_FIND_OR_ALLOCATE_MAP_DEFINES_SVH
`define ID_FIND_OR_ALLOCATE_MAP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IDFAM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IDFAM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/idfam_pkg.sv]
// Shared types and constants for the identifier find-or-allocate map.
// Depends on nothing; used by the controller, the top level and the checker.
`default_nettype none

package idfam_pkg;

    localparam int MAP_ENTRIES = 64;
    localparam int ID_W        = 32;
    localparam int IDX_W       = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAP_ENTRIES + 1);

    typedef enum logic [1:0] {
        OUT_HIT  = 2'd0,
        OUT_NEW  = 2'd1,
        OUT_FULL = 2'd2,
        OUT_OFF  = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        outcome_t        code;
    } idfam_res_t;

endpackage

`default_nettype wire

[src/idfam_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read. Depends on nothing.
`default_nettype none

module idfam_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[src/idfam_ctrl.sv]
// Search and allocate sequencer: walks the occupied entries one per cycle,
// appends on a miss while not full. Depends on idfam_pkg; drives both ports of idfam_ram.
`default_nettype none

module idfam_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_valid,
    input  wire logic                    cfg_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [idfam_pkg::ID_W-1:0]  s_gid,
    output logic                         ram_wr_en,
    output logic [idfam_pkg::IDX_W-1:0]  ram_wr_addr,
    output logic [idfam_pkg::ID_W-1:0]   ram_wr_data,
    output logic                         ram_rd_en,
    output logic [idfam_pkg::IDX_W-1:0]  ram_rd_addr,
    input  wire logic [idfam_pkg::ID_W-1:0]  ram_rd_data,
    output logic                         res_valid,
    input  wire logic                    res_ready,
    output idfam_pkg::idfam_res_t        res
);
    import idfam_pkg::*;

    ctrl_state_t      state_reg,  state_next;
    logic [IDX_W-1:0] idx_reg,    idx_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [ID_W-1:0]  gid_reg,    gid_next;
    idfam_res_t       res_reg,    res_next;
    logic             enable_reg, enable_next;

    logic [CNT_W-1:0] idx_plus;
    logic [CNT_W-1:0] count_plus;

    assign idx_plus   = CNT_W'(idx_reg) + CNT_W'(1);
    assign count_plus = count_reg + CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            enable_reg <= 1'b1;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            enable_reg <= enable_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        gid_reg <= gid_next;
        res_reg <= res_next;
    end

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        gid_next    = gid_reg;
        res_next    = res_reg;
        enable_next = enable_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = count_reg[IDX_W-1:0];
        ram_wr_data = gid_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;

        if (cfg_valid) begin
            enable_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    gid_next = s_gid;
                    if (!enable_reg) begin
                        res_next.id   = s_gid;
                        res_next.code = OUT_OFF;
                        state_next    = ST_RESULT;
                    end else if (count_reg == '0) begin
                        // Empty table: the first identifier goes straight to entry zero.
                        ram_wr_en     = 1'b1;
                        ram_wr_addr   = '0;
                        ram_wr_data   = s_gid;
                        count_next    = CNT_W'(1);
                        res_next.id   = ID_W'(1);
                        res_next.code = OUT_NEW;
                        state_next    = ST_RESULT;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        idx_next    = '0;
                        state_next  = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                // ram_rd_data holds the entry at idx_reg, read in the previous cycle.
                if (ram_rd_data == gid_reg) begin
                    res_next.id   = ID_W'(idx_plus);
                    res_next.code = OUT_HIT;
                    state_next    = ST_RESULT;
                end else if (idx_plus == count_reg) begin
                    if (count_reg != CNT_W'(MAP_ENTRIES)) begin
                        ram_wr_en     = 1'b1;
                        count_next    = count_plus;
                        res_next.id   = ID_W'(count_plus);
                        res_next.code = OUT_NEW;
                    end else begin
                        res_next.id   = gid_reg;
                        res_next.code = OUT_FULL;
                    end
                    state_next = ST_RESULT;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_plus[IDX_W-1:0];
                    idx_next    = idx_plus[IDX_W-1:0];
                end
            end
            ST_RESULT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESULT);
    assign res       = res_reg;

endmodule

`default_nettype wire

[src/id_find_or_allocate_map.sv]
// Top level of the identifier find-or-allocate map: stream ports, output
// register, sequencer and table memory. Depends on idfam_pkg, idfam_ctrl, idfam_ram.
`default_nettype none

//  Channel   Direction  Handshake             Payload
//  s_        in         s_tvalid / s_tready   s_tdata: global_id
//  m_        out        m_tvalid / m_tready   m_tdata: mapped_id, m_tuser: outcome
//  cfg_      in         cfg_valid / cfg_ready cfg_data: translate_enable
//
// An item whose identifier misses the table is compared with every occupied
// entry before the next word can be accepted; a hit at position k (local
// number k + 1) ends the search there, and an empty table or disabled
// translation skips it. The worst case, a miss on a full table, is set by the
// one-entry-per-cycle read port of the table. Reset clears the fill count but
// not the table memory, so the block is ready in the cycle after reset without
// a clearing pass. A stalled m_ side holds the result in the output register;
// the next word is accepted once that register can take its result.

module id_find_or_allocate_map (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input words. s_tdata[31:0] = global_id.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,
    // Result words. m_tdata[31:0] = mapped_id.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    // m_tuser[1:0] = outcome.
    output logic [1:0]       m_tuser,
    // Configuration. cfg_data[0] = translate_enable.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);
    import idfam_pkg::*;

    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    logic [ID_W-1:0]  ram_wr_data;
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_addr;
    logic [ID_W-1:0]  ram_rd_data;

    logic             res_valid;
    logic             res_ready;
    idfam_res_t       res;

    logic             out_valid_reg, out_valid_next;
    idfam_res_t       out_res_reg,   out_res_next;

    // The register is always writable; the user must write it only while the block is idle (not enforced).
    assign cfg_ready = 1'b1;

    idfam_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_gid       (s_tdata),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // The sequencer only writes after a miss and reads again only for the next
    // word, so a read never overlaps a write to the same entry.
    idfam_ram #(
        .DEPTH (MAP_ENTRIES),
        .WIDTH (ID_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Output register: takes a new result when empty or when its word leaves.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.id;
    assign m_tuser  = out_res_reg.code;

endmodule

`default_nettype wire

[src/idfam_checker.sv]
// Port-level checker for the identifier map, bound to the top level.
// Depends on idfam_pkg and id_find_or_allocate_map_defines.svh.
`default_nettype none
`include "id_find_or_allocate_map_defines.svh"

module idfam_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);
    import idfam_pkg::*;

    logic [31:0] last_new_reg, last_new_next;
    logic        out_take;
    logic        is_new;
    logic        is_local;

    assign out_take = m_tvalid && m_tready;
    assign is_new   = (m_tuser == OUT_NEW);
    assign is_local = (m_tuser == OUT_HIT) || (m_tuser == OUT_NEW);

    // Tracks the last local number handed out by an allocation.
    always_comb begin
        last_new_next = last_new_reg;
        if (out_take && is_new) begin
            last_new_next = m_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_new_reg <= '0;
        end else begin
            last_new_reg <= last_new_next;
        end
    end

    `IDFAM_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result word changed")

    `IDFAM_ASSERT_NOW(a_local_range, aclk, aresetn, m_tvalid && is_local, (m_tdata != 32'd0) && (m_tdata <= 32'(MAP_ENTRIES)), "local identifier out of range")

    `IDFAM_ASSERT_NOW(a_new_in_order, aclk, aresetn, out_take && is_new, m_tdata == last_new_reg + 32'd1, "allocation skipped or repeated a local number")

    `IDFAM_ASSERT_NOW(a_full_only_when_full, aclk, aresetn, out_take && (m_tuser == OUT_FULL), last_new_reg == 32'(MAP_ENTRIES), "full passthrough before the table filled")

    `IDFAM_ASSERT_NOW(a_hit_allocated, aclk, aresetn, out_take && (m_tuser == OUT_HIT), m_tdata <= last_new_reg, "hit on an entry never allocated")

endmodule

bind id_find_or_allocate_map idfam_checker u_idfam_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[tb/sv/id_find_or_allocate_map_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the identifier find-or-allocate map: watches the input, result and
// configuration channels, predicts each result and compares it. Depends on idfam_pkg.

module id_find_or_allocate_map_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    output int          mismatch_count,
    output int          outstanding,
    output int          hit_count,
    output int          alloc_count,
    output int          full_count,
    output int          off_count
);
    import idfam_pkg::*;

    // Shadow copy of the block state.
    logic [ID_W-1:0] shadow_table [MAP_ENTRIES];
    int              shadow_fill;
    logic            shadow_enable;

    idfam_res_t      pending_results [$];
    int              results_checked;

    initial begin
        mismatch_count = 0;
        outstanding    = 0;
        hit_count      = 0;
        alloc_count    = 0;
        full_count     = 0;
        off_count      = 0;
    end

    // Searches the occupied entries in order, appends on a miss while there is room,
    // and passes the identifier through when full or disabled.
    function automatic idfam_res_t find_or_allocate(input logic [ID_W-1:0] gid);
        idfam_res_t res;
        res.id   = gid;
        res.code = OUT_OFF;
        if (shadow_enable) begin
            res.code = OUT_FULL;
            for (int i = 0; i < shadow_fill; i++) begin
                if (shadow_table[i] == gid) begin
                    res.id   = ID_W'(i + 1);
                    res.code = OUT_HIT;
                    return res;
                end
            end
            if (shadow_fill < MAP_ENTRIES) begin
                shadow_table[shadow_fill] = gid;
                shadow_fill++;
                res.id   = ID_W'(shadow_fill);
                res.code = OUT_NEW;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] result %0d: %s mismatch, expected %h, got %h",
                     $time, results_checked, what, want_v, got_v);
    endtask

    always @(posedge aclk) begin
        idfam_res_t want;
        idfam_res_t got;
        if (!aresetn) begin
            shadow_enable = 1'b1;
            shadow_fill   = 0;
            pending_results.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                shadow_enable = cfg_data;

            if (m_tvalid && m_tready) begin
                got.id   = m_tdata;
                got.code = outcome_t'(m_tuser);
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result word", '0, m_tdata);
                end else begin
                    want = pending_results.pop_front();
                    if (got.id !== want.id)
                        report_mismatch("mapped_id", want.id, got.id);
                    if (got.code !== want.code)
                        report_mismatch("outcome", 32'(want.code), 32'(got.code));
                    case (want.code)
                        OUT_HIT:  hit_count++;
                        OUT_NEW:  alloc_count++;
                        OUT_FULL: full_count++;
                        default:  off_count++;
                    endcase
                end
                results_checked++;
            end

            if (s_tvalid && s_tready)
                pending_results.push_back(find_or_allocate(s_tdata));
        end
        outstanding <= pending_results.size();
    end

endmodule

[tb/sv/id_find_or_allocate_map_tb.sv]
`timescale 1ns / 1ps
// Top of the identifier find-or-allocate map testbench: clock, reset, stimulus and verdict.
// Depends on idfam_pkg, id_find_or_allocate_map and id_find_or_allocate_map_checker.

module id_find_or_allocate_map_tb;
    import idfam_pkg::*;

    // Translation setting for each random phase, phase 0 in bit 0. Both values
    // appear, and repeated writes of the same value are included on purpose.
    localparam logic [6:0] PHASE_ENABLE    = 7'b1101101;
    localparam int         PHASES          = 7;
    localparam int         WORDS_PER_PHASE = 250;
    // The earliest identifiers sent live at the front of the history, so picks
    // from this window are the ones most likely to hit.
    localparam int         HOT_WINDOW      = MAP_ENTRIES + 16;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;

    int mismatch_count;
    int outstanding;
    int hit_count;
    int alloc_count;
    int full_count;
    int off_count;

    // Quiet mode turns off all idling on both sides for the tail of the run.
    logic quiet = 1'b0;
    int   stall_left = 0;

    logic [31:0] sent_ids [$];
    int          words_sent = 0;
    int          cfg_writes = 0;

    id_find_or_allocate_map u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [31:0] global_id
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [31:0] mapped_id
        .m_tuser   (m_tuser),   // [1:0] outcome
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)   // [0] translate_enable
    );

    id_find_or_allocate_map_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .hit_count      (hit_count),
        .alloc_count    (alloc_count),
        .full_count     (full_count),
        .off_count      (off_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver side: stalls come in bursts of random length, each burst starting
    // at random, with runs of full readiness in between.
    always @(posedge aclk) begin
        if (!aresetn || quiet) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Presents one word and returns at the edge where it is accepted. The valid
    // stays high afterwards, so back-to-back words need no extra assignment.
    task automatic send_id(input logic [31:0] gid);
        s_tvalid <= 1'b1;
        s_tdata  <= gid;
        do @(posedge aclk); while (!s_tready);
        sent_ids.push_back(gid);
        words_sent++;
    endtask

    task automatic sender_gap(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Holds the sender off until the checker has seen every result it expects.
    // The first edge lets the count pick up a word accepted at the current one.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Every word yields exactly one result, so the block is idle once the
    // last expected result has left; the register is written only then.
    task automatic write_translate_enable(input logic enable);
        wait_all_results();
        cfg_valid <= 1'b1;
        cfg_data  <= enable;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Mix of identifiers: repeats of early words (mostly hits while enabled),
    // repeats from the whole history, single-bit neighbors of earlier words
    // (near misses) and fresh random values.
    function automatic logic [31:0] pick_global_id();
        logic [31:0] gid;
        int          roll;
        int          span;
        roll = $urandom_range(0, 99);
        span = (sent_ids.size() < HOT_WINDOW) ? sent_ids.size() : HOT_WINDOW;
        if (sent_ids.size() == 0 || roll >= 75) begin
            gid = $urandom();
        end else if (roll < 40) begin
            gid = sent_ids[$urandom_range(0, span - 1)];
        end else begin
            gid = sent_ids[$urandom_range(0, sent_ids.size() - 1)];
            if (roll >= 65)
                gid[$urandom_range(0, 31)] ^= 1'b1;
        end
        return gid;
    endfunction

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. Translation is on after reset, and the table starts
        // empty: allocate the extreme identifiers, then hit them again.
        send_id(32'h0000_0000);
        send_id(32'h0000_0000);
        send_id(32'hFFFF_FFFF);
        send_id(32'hFFFF_FFFF);
        send_id(32'h8000_0000);
        send_id(32'h0000_0001);
        send_id(32'h7FFF_FFFF);
        send_id(32'h0000_0001);
        send_id(32'h8000_0000);

        // Disabled translation passes identifiers through, known or not, and
        // must leave the table alone.
        write_translate_enable(1'b0);
        send_id(32'h0000_0000);
        send_id(32'hFFFF_FFFF);
        send_id(32'h1234_5678);
        send_id(32'hA5A5_A5A5);

        // Back on: the earlier entries must still be at their positions, and an
        // identifier first seen while disabled must allocate a fresh entry.
        write_translate_enable(1'b1);
        send_id(32'hFFFF_FFFF);
        send_id(32'h1234_5678);
        send_id(32'h7FFF_FFFF);
        send_id(32'h1234_5678);

        // Random part. The table fills early in phase 0 and stays full for the
        // rest of the run, so later phases exercise hits at every position and
        // full-table passthrough, interleaved with disabled phases.
        for (int phase = 0; phase < PHASES; phase++) begin
            write_translate_enable(PHASE_ENABLE[phase]);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (phase == PHASES - 1 && n == WORDS_PER_PHASE / 2)
                    quiet <= 1'b1;
                // Let the pipeline run completely dry once in every phase.
                if (n == WORDS_PER_PHASE / 3)
                    wait_all_results();
                else if (!quiet && $urandom_range(0, 3) == 0)
                    sender_gap($urandom_range(1, 7));
                send_id(pick_global_id());
            end
        end

        wait_all_results();
        repeat (MAP_ENTRIES + 8) @(posedge aclk);

        $display("Run summary: %0d words sent, %0d translate_enable writes.",
                 words_sent, cfg_writes);
        $display("Outcomes checked: %0d hit, %0d allocated, %0d full, %0d disabled.",
                 hit_count, alloc_count, full_count, off_count);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("id_find_or_allocate_map test passed");
        end else begin
            $display("id_find_or_allocate_map test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #(10_000_000);
        $display("Timeout with %0d results still expected.", outstanding);
        $display("id_find_or_allocate_map test failed");
        $finish;
    end

endmodule
